// ===== src/agpl_pkg.sv =====
`default_nettype none

package agpl_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 11;
    localparam int LIMIT_W     = 15;
    localparam int COEFF_W     = 24;
    localparam int QUO_W       = 24;
    localparam int LG_W        = QUO_W + 1;

    // amplified magnitude: |sample| <= 2^(SB-1), gain < 2^16
    localparam int AMP_W   = SAMPLE_BITS + GAIN_W - 1;
    localparam int CEIL_W  = LIMIT_W + GAIN_FRAC;
    localparam int REM_W   = (AMP_W > CEIL_W) ? AMP_W : CEIL_W;
    localparam int PROD_W  = LG_W + COEFF_W;
    localparam int YPROD_W = AMP_W + LG_W;
    localparam int OUT_SH  = QUO_W + GAIN_FRAC;
    localparam int YMAG_W  = YPROD_W + 1 - OUT_SH;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [LG_W-1:0]    ONE_Q24   = {1'b1, {QUO_W{1'b0}}};
    localparam logic [YPROD_W:0]   RND_HALF  = (YPROD_W + 1)'(1) << (OUT_SH - 1);
    localparam logic [YMAG_W-1:0]  POS_MAX   = (YMAG_W)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [YMAG_W-1:0]  NEG_MAX   = (YMAG_W)'(1) << (SAMPLE_BITS - 1);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COEFF_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REL   = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd2048;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd32767;
    localparam logic [COEFF_W-1:0] COEFF_RST = 24'd2621;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
        logic [COEFF_W-1:0] coeff;
    } t_cfg;

    // one classified item on its way to the back end
    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic             neg;
        logic             last;
        logic             lim;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REL,
        S_GAIN,
        S_MUL,
        S_OUT
    } t_bstate;

    // limit level moved to the Q.11 scale of the amplified magnitude
    function automatic logic [REM_W-1:0] ceil_of(input logic [LIMIT_W-1:0] lim);
        ceil_of = (REM_W)'({lim, {GAIN_FRAC{1'b0}}});
    endfunction

endpackage

`default_nettype wire

// ===== src/agpl_front.sv =====
`default_nettype none

module agpl_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic signed [agpl_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                 i_last,
    output logic                                      o_stall,
    input  wire agpl_pkg::t_cfg                       i_cfg,
    input  wire logic                                 i_q_full,
    output logic                                      o_push,
    output agpl_pkg::t_job                            o_job
);

    logic [agpl_pkg::SAMPLE_BITS-1:0]                   w_raw;
    logic                                               w_neg;
    logic [agpl_pkg::SAMPLE_BITS-1:0]                   w_smag;
    logic [agpl_pkg::SAMPLE_BITS+agpl_pkg::GAIN_W-1:0]  w_prod;
    logic                                               w_acc;

    logic                        r_fv;
    logic [agpl_pkg::AMP_W-1:0]  r_amp;
    logic                        r_neg;
    logic                        r_last;

    // magnitude times gain
    always_comb begin
        w_raw  = i_sample;
        w_neg  = w_raw[agpl_pkg::SAMPLE_BITS-1];
        w_smag = w_neg ? (~w_raw + 1'b1) : w_raw;
        w_prod = w_smag * i_cfg.gain;
    end

    assign o_stall = r_fv & i_q_full;
    assign w_acc   = i_valid & ~o_stall;
    assign o_push  = r_fv & ~i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_amp  <= w_prod[agpl_pkg::AMP_W-1:0];
            r_neg  <= w_neg;
            r_last <= i_last;
        end
    end

    // classify: does this item need a division
    always_comb begin
        o_job.amp  = r_amp;
        o_job.neg  = r_neg;
        o_job.last = r_last;
        o_job.lim  = (agpl_pkg::REM_W)'(r_amp) > agpl_pkg::ceil_of(i_cfg.limit);
    end

endmodule

`default_nettype wire

// ===== src/agpl_queue.sv =====
`default_nettype none

module agpl_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire agpl_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output agpl_pkg::t_job      o_job,
    output logic                o_valid
);

    agpl_pkg::t_job                r_mem [agpl_pkg::Q_DEPTH];
    logic [agpl_pkg::Q_PTR_W-1:0]  r_wp;
    logic [agpl_pkg::Q_PTR_W-1:0]  r_rp;
    logic [agpl_pkg::Q_PTR_W:0]    r_cnt;

    assign o_full  = r_cnt == (agpl_pkg::Q_PTR_W + 1)'(agpl_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers wrap on their own, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/agpl_back.sv =====
`default_nettype none

module agpl_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire agpl_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_q_valid,
    input  wire agpl_pkg::t_job                        i_job,
    output logic                                       o_pop,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [agpl_pkg::SAMPLE_BITS-1:0]    o_sample,
    output logic                                       o_last
);

    agpl_pkg::t_bstate r_state;
    agpl_pkg::t_bstate n_state;

    agpl_pkg::t_job                   r_job;
    logic [agpl_pkg::REM_W-1:0]       r_rem;
    logic [agpl_pkg::QUO_W-1:0]       r_quo;
    logic [agpl_pkg::CNT_W-1:0]       r_cnt;
    logic [agpl_pkg::LG_W-1:0]        r_lg;
    logic [agpl_pkg::PROD_W-1:0]      r_prod;
    logic [agpl_pkg::YPROD_W-1:0]     r_yprod;
    logic                             r_ov;
    logic [agpl_pkg::SAMPLE_BITS-1:0] r_osample;
    logic                             r_olast;

    logic                             w_out_free;
    logic                             w_load_out;
    logic [agpl_pkg::REM_W:0]         w_shift;
    logic [agpl_pkg::REM_W:0]         w_diff;
    logic [agpl_pkg::LG_W-1:0]        w_req;
    logic [agpl_pkg::LG_W-1:0]        w_dist;
    logic [agpl_pkg::LG_W-1:0]        w_inc;
    logic [agpl_pkg::LG_W:0]          w_sum;
    logic [agpl_pkg::LG_W-1:0]        w_rel;
    logic [agpl_pkg::YPROD_W:0]       w_rnd;
    logic [agpl_pkg::YMAG_W-1:0]      w_ymag;
    logic [agpl_pkg::YMAG_W-1:0]      w_ysat;
    logic [agpl_pkg::SAMPLE_BITS-1:0] w_res;

    assign w_out_free = ~r_ov | ~i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            agpl_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_job.lim ? agpl_pkg::S_DIV : agpl_pkg::S_REL;
                end
            end
            agpl_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = agpl_pkg::S_REL;
                end
            end
            agpl_pkg::S_REL:  n_state = agpl_pkg::S_GAIN;
            agpl_pkg::S_GAIN: n_state = agpl_pkg::S_MUL;
            agpl_pkg::S_MUL:  n_state = agpl_pkg::S_OUT;
            agpl_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = agpl_pkg::S_IDLE;
                end
            end
            default: n_state = agpl_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            agpl_pkg::S_IDLE: o_pop      = i_q_valid;
            agpl_pkg::S_OUT:  w_load_out = w_out_free;
            default: begin
                o_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= agpl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring divider step: quotient bit of limit*2^35 / amp
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, (agpl_pkg::REM_W)'(r_job.amp)};
    end

    // required gain, release step
    always_comb begin
        w_req  = r_job.lim ? {1'b0, r_quo} : agpl_pkg::ONE_Q24;
        w_dist = agpl_pkg::ONE_Q24 - r_lg;
        // ceiling of prod / 2^24
        w_inc  = r_prod[agpl_pkg::PROD_W-1:agpl_pkg::QUO_W]
               + (agpl_pkg::LG_W)'(|r_prod[agpl_pkg::QUO_W-1:0]);
        w_sum  = {1'b0, r_lg} + {1'b0, w_inc};
        w_rel  = (w_sum > {1'b0, agpl_pkg::ONE_Q24}) ? agpl_pkg::ONE_Q24
                                                    : w_sum[agpl_pkg::LG_W-1:0];
    end

    // round half away from zero on the magnitude, then saturate
    always_comb begin
        w_rnd  = {1'b0, r_yprod} + agpl_pkg::RND_HALF;
        w_ymag = w_rnd[agpl_pkg::YPROD_W:agpl_pkg::OUT_SH];
        if (r_job.neg) begin
            w_ysat = (w_ymag > agpl_pkg::NEG_MAX) ? agpl_pkg::NEG_MAX : w_ymag;
            w_res  = ~w_ysat[agpl_pkg::SAMPLE_BITS-1:0] + 1'b1;
        end else begin
            w_ysat = (w_ymag > agpl_pkg::POS_MAX) ? agpl_pkg::POS_MAX : w_ymag;
            w_res  = w_ysat[agpl_pkg::SAMPLE_BITS-1:0];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_rem <= agpl_pkg::ceil_of(i_cfg.limit);
            r_quo <= '0;
            r_cnt <= (agpl_pkg::CNT_W)'(agpl_pkg::QUO_W - 1);
        end
        if (r_state == agpl_pkg::S_DIV) begin
            if (!w_diff[agpl_pkg::REM_W]) begin
                r_rem <= w_diff[agpl_pkg::REM_W-1:0];
            end else begin
                r_rem <= w_shift[agpl_pkg::REM_W-1:0];
            end
            r_quo <= {r_quo[agpl_pkg::QUO_W-2:0], ~w_diff[agpl_pkg::REM_W]};
            r_cnt <= r_cnt - 1'b1;
        end
        if (r_state == agpl_pkg::S_REL) begin
            r_prod <= w_dist * i_cfg.coeff;
        end
        if (r_state == agpl_pkg::S_MUL) begin
            r_yprod <= r_job.amp * r_lg;
        end
        if (w_load_out) begin
            r_osample <= w_res;
            r_olast   <= r_job.last;
        end
    end

    // limiter gain: 1.0 after reset or a register write; instant attack, otherwise release toward 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_lg <= agpl_pkg::ONE_Q24;
        end else if (r_state == agpl_pkg::S_GAIN) begin
            r_lg <= (w_req < r_lg) ? w_req : w_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid  = r_ov;
    assign o_sample = r_osample;
    assign o_last   = r_olast;

endmodule

`default_nettype wire

// ===== src/audio_gain_peak_limiter_top.sv =====
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_stall    | i_sample_in, i_frame_last_in
// output   | out       | o_out_valid / i_out_stall  | o_sample_out, o_frame_last_out
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item that is limited goes through the 24-step radix-2 divider in the back
// end; an item below the limit skips it. The front takes one item per cycle,
// unless the queue is full, into a two-entry queue, so up to five items can be
// in flight. Reset is synchronous, active low; it restores the register
// defaults and a limiter gain of 1.0. A stalled output holds its item while
// the front goes on filling the queue.
`default_nettype none

module audio_gain_peak_limiter_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [agpl_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                                  i_frame_last_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [agpl_pkg::SAMPLE_BITS-1:0]    o_sample_out,
    output logic                                       o_frame_last_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [agpl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [agpl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    agpl_pkg::t_cfg r_cfg;
    agpl_pkg::t_cfg n_cfg;
    logic           w_cfg_hit;

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_qv;
    agpl_pkg::t_job w_fjob;
    agpl_pkg::t_job w_qjob;

    assign o_cfg_ready = 1'b1;

    // register decode
    always_comb begin
        n_cfg     = r_cfg;
        w_cfg_hit = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                agpl_pkg::CFG_GAIN: begin
                    n_cfg.gain = i_cfg_data[agpl_pkg::GAIN_W-1:0];
                    w_cfg_hit  = 1'b1;
                end
                agpl_pkg::CFG_LIMIT: begin
                    n_cfg.limit = i_cfg_data[agpl_pkg::LIMIT_W-1:0];
                    w_cfg_hit   = 1'b1;
                end
                agpl_pkg::CFG_REL: begin
                    n_cfg.coeff = i_cfg_data[agpl_pkg::COEFF_W-1:0];
                    w_cfg_hit   = 1'b1;
                end
                default: w_cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain  <= agpl_pkg::GAIN_RST;
            r_cfg.limit <= agpl_pkg::LIMIT_RST;
            r_cfg.coeff <= agpl_pkg::COEFF_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    agpl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_sample (i_sample_in),
        .i_last   (i_frame_last_in),
        .o_stall  (o_in_stall),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_fjob)
    );

    agpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_valid (w_qv)
    );

    agpl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cfg_we  (w_cfg_hit),
        .i_q_valid (w_qv),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_sample  (o_sample_out),
        .o_last    (o_frame_last_out)
    );

endmodule

`default_nettype wire

// ===== src/agpl_chk.sv =====
`default_nettype none

module agpl_chk (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    i_in_valid,
    input wire logic                                    o_in_stall,
    input wire logic                                    o_out_valid,
    input wire logic                                    i_out_stall,
    input wire logic signed [agpl_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input wire logic                                    o_frame_last_out
);

    // front register, queue, back job and output register
    localparam logic [3:0] MAX_INFLIGHT = 4'd5;

    logic [3:0] r_pend;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid & ~o_in_stall;
    assign w_out_acc = o_out_valid & ~i_out_stall;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out)
            && $stable(o_frame_last_out))
        else $error("stalled output item changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("output item with no input item outstanding");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= MAX_INFLIGHT)
        else $error("more items in flight than the block can hold");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind audio_gain_peak_limiter_top agpl_chk u_agpl_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_sample_out     (o_sample_out),
    .o_frame_last_out (o_frame_last_out)
);

`default_nettype wire
